// File: design/assert_macros.svh
// assert_macros.svh: assertion macros used by the checker file brr_checker.sv.
// Depends on nothing; the including module must have clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held
`define BRR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked assertion that also holds while reset is held
`define BRR_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: design/brr_pkg.sv
// brr_pkg: types and constants of the backfill record reassembler.
// No dependencies; used by the core, output buffer and top level.
package brr_pkg;

  // Bytes per record, header bytes, bytes skipped in the first packet
  localparam int unsigned REC_BYTES  = 8;
  localparam int unsigned HDR_BYTES  = 2;
  localparam int unsigned FIRST_SKIP = 6;

  localparam logic [2:0] FILL_LAST = 3'(REC_BYTES - 1);
  localparam logic [2:0] POS_MAX   = 3'(FIRST_SKIP);
  localparam logic [2:0] POS_HDR   = 3'(HDR_BYTES);
  localparam logic [2:0] POS_SEQ   = 3'd0;
  localparam logic [2:0] POS_ID    = 3'd1;
  localparam logic [7:0] SEQ_FIRST = 8'd1;
  localparam logic [7:0] SEQ_LOST  = 8'd0;

  // Input word kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_BYTE  = 1'b1;

  typedef enum logic [1:0] {
    ST_PENDING  = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_REJECTED = 2'd2
  } pkt_status_e;

  // One result word
  typedef struct packed {
    logic        record_valid;
    logic [31:0] record_time;
    logic [15:0] glucose_value;
    logic [7:0]  record_type;
    logic [7:0]  trend_value;
    logic        packet_end;
    logic        packet_accepted;
  } result_t;

endpackage

// File: design/brr_core.sv
// brr_core: packet sequence check and record packing state.
// Depends on brr_pkg; produces a result word when an accepted byte completes a record or ends a packet.
module brr_core import brr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    accept_i,
  input  logic    kind_i,
  input  logic [7:0] data_byte_i,
  input  logic    last_in_packet_i,
  output logic    res_valid_o,
  output result_t res_o
);

  logic [7:0]  expected_q, expected_d;
  logic [7:0]  held_q, held_d;
  logic [2:0]  pos_q, pos_d;
  pkt_status_e status_q, status_d, status_upd;
  logic        first_q, first_d;
  logic [55:0] rec_q, rec_d;
  logic [2:0]  fill_q, fill_d;

  logic        is_byte;
  logic        take_payload;
  logic        rec_done;
  logic [2:0]  skip_pos;

  // Payload byte qualification
  assign is_byte      = (kind_i == KIND_BYTE);
  assign skip_pos     = first_q ? POS_MAX : POS_HDR;
  assign take_payload = (pos_q != POS_SEQ) && (pos_q != POS_ID) &&
                        (status_q == ST_ACCEPTED) && (pos_q >= skip_pos);
  assign rec_done     = take_payload && (fill_q == FILL_LAST);

  // Next state
  always_comb begin
    expected_d = expected_q;
    held_d     = held_q;
    pos_d      = pos_q;
    status_upd = status_q;
    first_d    = first_q;
    rec_d      = rec_q;
    fill_d     = fill_q;
    if (accept_i) begin
      if (!is_byte) begin
        // start of backfill: everything back to reset
        expected_d = SEQ_FIRST;
        held_d     = '0;
        pos_d      = '0;
        status_upd = ST_PENDING;
        first_d    = 1'b0;
        rec_d      = '0;
        fill_d     = '0;
      end else begin
        if (pos_q == POS_SEQ) begin
          held_d = data_byte_i;
        end else if (pos_q == POS_ID) begin
          if (held_q != expected_q) begin
            expected_d = SEQ_LOST;
            status_upd = ST_REJECTED;
          end else begin
            expected_d = expected_q + 8'd1;
            status_upd = ST_ACCEPTED;
            if (held_q == SEQ_FIRST) begin
              first_d = 1'b1;
              rec_d   = '0;
              fill_d  = '0;
            end
          end
        end else if (take_payload) begin
          if (rec_done) begin
            rec_d  = '0;
            fill_d = '0;
          end else begin
            rec_d  = rec_q | (56'(data_byte_i) << {fill_q, 3'b000});
            fill_d = fill_q + 3'd1;
          end
        end
        if (pos_q < POS_MAX) begin
          pos_d = pos_q + 3'd1;
        end
        // packet end: per-packet state returns to reset
        if (last_in_packet_i) begin
          pos_d   = '0;
          first_d = 1'b0;
          held_d  = '0;
        end
      end
    end
  end

  always_comb begin
    status_d = status_upd;
    if (accept_i && is_byte && last_in_packet_i) begin
      status_d = ST_PENDING;
    end
  end

  // Result word
  always_comb begin
    res_o             = '0;
    res_valid_o       = accept_i && is_byte && (rec_done || last_in_packet_i);
    res_o.packet_end  = last_in_packet_i;
    res_o.packet_accepted = last_in_packet_i && (status_upd == ST_ACCEPTED);
    if (rec_done) begin
      res_o.record_valid  = 1'b1;
      res_o.record_time   = rec_q[31:0];
      res_o.glucose_value = rec_q[47:32];
      res_o.record_type   = rec_q[55:48];
      res_o.trend_value   = data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q <= SEQ_FIRST;
      held_q     <= '0;
      pos_q      <= '0;
      status_q   <= ST_PENDING;
      first_q    <= 1'b0;
      rec_q      <= '0;
      fill_q     <= '0;
    end else begin
      expected_q <= expected_d;
      held_q     <= held_d;
      pos_q      <= pos_d;
      status_q   <= status_d;
      first_q    <= first_d;
      rec_q      <= rec_d;
      fill_q     <= fill_d;
    end
  end

endmodule

// File: design/brr_out_buf.sv
// brr_out_buf: output register with one skid entry for result words.
// Depends on brr_pkg for the result word type.
module brr_out_buf import brr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    full_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_data_o
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    out_free;

  // Output slot can load when empty or when its word leaves this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else if (push_i) begin
        out_d       = push_data_i;
        out_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (push_i) begin
      skid_d       = push_data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: design/backfill_record_reassembler.sv
// backfill_record_reassembler: top level of the backfill record reassembler.
// Depends on brr_pkg, brr_core and brr_out_buf.
//
// Input channel: one word per handshake (in_valid_i high, in_stall_o low).
// kind_i = 0 starts a backfill; kind_i = 1 carries one packet byte in
// data_byte_i, with last_in_packet_i marking the final byte of a packet.
// Output channel: a word is produced when a byte completes an 8-byte record
// or ends a packet, and is taken when out_valid_o is high and out_stall_i low.
// A result passes from the core, which is combinational, into the output
// register. Throughput: one input word per cycle while in_stall_o is low, set by
// the single register stage of sequence and record state.
// When the receiver stalls, the output word holds and one more result goes
// into a skid entry; in_stall_o rises while that entry is occupied.
// Reset (rst_ni low, asynchronous) sets the expected sequence to 1, clears
// the pending record bytes and empties the output register and skid entry.
module backfill_record_reassembler import brr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_in_packet_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        record_valid_o,
  output logic [31:0] record_time_o,
  output logic [15:0] glucose_value_o,
  output logic [7:0]  record_type_o,
  output logic [7:0]  trend_value_o,
  output logic        packet_end_o,
  output logic        packet_accepted_o
);

  logic    accept;
  logic    res_valid;
  logic    buf_full;
  result_t res;
  result_t out_data;

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  brr_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .kind_i          (kind_i),
    .data_byte_i     (data_byte_i),
    .last_in_packet_i(last_in_packet_i),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  brr_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res),
    .full_o     (buf_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data)
  );

  // Result fields to ports
  assign record_valid_o    = out_data.record_valid;
  assign record_time_o     = out_data.record_time;
  assign glucose_value_o   = out_data.glucose_value;
  assign record_type_o     = out_data.record_type;
  assign trend_value_o     = out_data.trend_value;
  assign packet_end_o      = out_data.packet_end;
  assign packet_accepted_o = out_data.packet_accepted;

endmodule

// File: design/brr_checker.sv
// brr_checker: port-level assertions for the backfill record reassembler.
// Depends on assert_macros.svh; bound to the top level below.
`include "assert_macros.svh"

module brr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        record_valid_o,
  input logic [31:0] record_time_o,
  input logic [15:0] glucose_value_o,
  input logic [7:0]  record_type_o,
  input logic [7:0]  trend_value_o,
  input logic        packet_end_o,
  input logic        packet_accepted_o
);

  // A stalled output word stays put
  `BRR_ASSERT(a_out_hold,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(record_valid_o) &&
      $stable(record_time_o) && $stable(glucose_value_o) && $stable(record_type_o) &&
      $stable(trend_value_o) && $stable(packet_end_o) && $stable(packet_accepted_o),
    "stalled output word changed")

  // Every word carries a record or a packet end
  `BRR_ASSERT(a_out_content, out_valid_o |-> record_valid_o || packet_end_o, "empty output word")

  // Accept flag only at a packet end; record fields zero without a record
  `BRR_ASSERT(a_out_zero,
    out_valid_o && !record_valid_o |-> (record_time_o == '0) && (glucose_value_o == '0) &&
      (record_type_o == '0) && (trend_value_o == '0) && (packet_end_o || !packet_accepted_o),
    "idle fields not zero")

  // Input stalls only while the output word is also held
  `BRR_ASSERT(a_stall_full, in_stall_o |-> out_valid_o, "input stall without output word")

  // Nothing presented or stalled once reset has been seen at an edge
  `BRR_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o && !in_stall_o, "busy during reset")

endmodule

bind backfill_record_reassembler brr_checker u_brr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .record_valid_o   (record_valid_o),
  .record_time_o    (record_time_o),
  .glucose_value_o  (glucose_value_o),
  .record_type_o    (record_type_o),
  .trend_value_o    (trend_value_o),
  .packet_end_o     (packet_end_o),
  .packet_accepted_o(packet_accepted_o)
);
